// ===== rtl/core/pbd_pkg.sv =====
`timescale 1ns / 1ps

package pbd_pkg;

  // field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPAN_W     = 22;
  localparam int unsigned DIFF_W     = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned WINDOW_W   = 5;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned IGNORE_W   = 11;
  localparam int unsigned GAP_W      = 12;

  // thresholds kept in milliseconds
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned NO_LATER_SEC = 2;
  localparam int unsigned WIN_LIM_W    = 15;
  localparam int unsigned GAP_LIM_W    = 22;

  // register reset values
  localparam logic [COUNT_W-1:0]   COUNT_RST   = COUNT_W'(3);
  localparam logic [IGNORE_W-1:0]  IGNORE_RST  = IGNORE_W'(300);
  localparam logic [WIN_LIM_W-1:0] WIN_LIM_RST = WIN_LIM_W'((5 + 1) * MS_PER_SEC);
  localparam logic [GAP_LIM_W-1:0] GAP_LIM_RST = GAP_LIM_W'(2 * MS_PER_SEC);
  localparam logic [GAP_LIM_W-1:0] NO_LATER_LIM = GAP_LIM_W'(NO_LATER_SEC * MS_PER_SEC);

  // divide by 1000 as (x >> 3) / 125 through a reciprocal multiply
  localparam int unsigned DIV_PRE_SHIFT = 3;
  localparam int unsigned QUOT_IN_W     = DIFF_W - DIV_PRE_SHIFT;
  localparam int unsigned RECIP_W       = 29;
  localparam int unsigned RECIP_SHIFT   = 35;
  localparam int unsigned PROD_W        = QUOT_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(274877907);

  // depth of the queue between front and back
  localparam int unsigned MID_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_DISABLED      = 3'd0,
    ST_RESYNC        = 3'd1,
    ST_TOO_FAST      = 3'd2,
    ST_NOT_ENOUGH    = 3'd3,
    ST_WINDOW_MISSED = 3'd4,
    ST_RATE_LIMITED  = 3'd5,
    ST_REPORTED      = 3'd6,
    ST_SPAN_ERROR    = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_ENABLE  = 3'd0,
    CFG_WINDOW_SECONDS = 3'd1,
    CFG_PRESS_COUNT    = 3'd2,
    CFG_IGNORE_MS      = 3'd3,
    CFG_REPORT_GAP     = 3'd4
  } cfg_idx_e;

  // classified press handed from front to back
  typedef struct packed {
    status_e             status;
    logic [DIFF_W-1:0]   diff;
  } press_word_t;

endpackage

// ===== rtl/core/pbd_fifo.sv =====
`timescale 1ns / 1ps

module pbd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pbd_pkg::press_word_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output pbd_pkg::press_word_t data_o,
  output logic                empty_o
);
  import pbd_pkg::*;

  localparam int unsigned PtrW = $clog2(MID_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  press_word_t         mem_q [MID_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(MID_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // fill count stays within the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MID_DEPTH))
    else $error("queue count over depth");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

endmodule

// ===== rtl/core/pbd_front.sv =====
`timescale 1ns / 1ps

module pbd_front #(
  parameter int unsigned MAX_PRESSES = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic [pbd_pkg::TIME_W-1:0]          press_time_ms_i,
  output logic                                q_push_o,
  output pbd_pkg::press_word_t                q_word_o
);
  import pbd_pkg::*;

  localparam int unsigned Depth = MAX_PRESSES + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned HeldW = IdxW + 1;
  localparam int unsigned CmpW  = (HeldW > COUNT_W) ? HeldW : COUNT_W;

  // configuration registers
  logic                  detect_enable_q;
  logic [COUNT_W-1:0]    press_count_q;
  logic [IGNORE_W-1:0]   ignore_ms_q;
  logic [WIN_LIM_W-1:0]  win_lim_q;
  logic [GAP_LIM_W-1:0]  gap_lim_q;

  // detector state
  logic [IdxW-1:0]       newest_q, newest_d;
  logic [IdxW-1:0]       oldest_q, oldest_d;
  logic [TIME_W-1:0]     last_accept_q, last_accept_d;
  logic [TIME_W-1:0]     last_report_q, last_report_d;
  logic [TIME_W-1:0]     ring_mem [Depth];
  logic [TIME_W-1:0]     oldest_rd_q;

  logic                  accept;
  logic                  ring_we;
  status_e               status;
  logic [HeldW-1:0]      held;
  logic [TIME_W-1:0]     oldest_val;
  logic [TIME_W-1:0]     diff;
  logic [TIME_W-1:0]     since_accept;
  logic [TIME_W-1:0]     since_report;
  logic                  too_fast;
  logic                  too_few;
  logic                  in_window;
  logic                  gap_short;
  logic                  rate_limited;
  logic [IdxW-1:0]       newest_nx;
  logic [IdxW-1:0]       oldest_nx;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !full_i;

  // register writes, window and gap limits kept in ms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_enable_q <= 1'b0;
      press_count_q   <= COUNT_RST;
      ignore_ms_q     <= IGNORE_RST;
      win_lim_q       <= WIN_LIM_RST;
      gap_lim_q       <= GAP_LIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DETECT_ENABLE: begin
          detect_enable_q <= cfg_data_i[0];
        end
        CFG_WINDOW_SECONDS: begin
          win_lim_q <= WIN_LIM_W'((WIN_LIM_W'(cfg_data_i[WINDOW_W-1:0]) + WIN_LIM_W'(1))
                       * WIN_LIM_W'(MS_PER_SEC));
        end
        CFG_PRESS_COUNT: begin
          press_count_q <= cfg_data_i[COUNT_W-1:0];
        end
        CFG_IGNORE_MS: begin
          ignore_ms_q <= cfg_data_i[IGNORE_W-1:0];
        end
        CFG_REPORT_GAP: begin
          gap_lim_q <= GAP_LIM_W'(GAP_LIM_W'(cfg_data_i[GAP_W-1:0]) * GAP_LIM_W'(MS_PER_SEC));
        end
        default: begin
        end
      endcase
    end
  end

  // ring slot arithmetic
  assign newest_nx = (newest_q == IdxW'(MAX_PRESSES)) ? '0 : newest_q + IdxW'(1);
  assign oldest_nx = (oldest_q == IdxW'(MAX_PRESSES)) ? '0 : oldest_q + IdxW'(1);
  assign held = (newest_q >= oldest_q)
              ? HeldW'(newest_q) - HeldW'(oldest_q)
              : HeldW'(newest_q) + HeldW'(Depth) - HeldW'(oldest_q);

  // oldest press time, the incoming one when the ring is empty
  assign oldest_val = (newest_q == oldest_q) ? press_time_ms_i : oldest_rd_q;
  assign diff       = press_time_ms_i - oldest_val;

  // threshold compares, all in milliseconds
  assign since_accept = press_time_ms_i - last_accept_q;
  assign since_report = press_time_ms_i - last_report_q;
  assign too_fast     = since_accept < TIME_W'(ignore_ms_q);
  assign too_few      = (press_count_q == '0)
                     || ((CmpW'(held) + CmpW'(1)) < CmpW'(press_count_q));
  assign in_window    = diff < TIME_W'(win_lim_q);
  assign gap_short    = (press_time_ms_i > last_report_q)
                      ? (since_report < TIME_W'(gap_lim_q))
                      : (gap_lim_q > NO_LATER_LIM);
  assign rate_limited = (last_report_q != '0) && gap_short;

  // classification and next state
  always_comb begin
    status        = ST_DISABLED;
    ring_we       = 1'b0;
    newest_d      = newest_q;
    oldest_d      = oldest_q;
    last_accept_d = last_accept_q;
    last_report_d = last_report_q;
    priority if (!detect_enable_q) begin
      status = ST_DISABLED;
    end else if (last_accept_q > press_time_ms_i) begin
      status        = ST_RESYNC;
      last_accept_d = press_time_ms_i;
    end else if (too_fast) begin
      status = ST_TOO_FAST;
    end else begin
      last_accept_d = press_time_ms_i;
      ring_we       = 1'b1;
      priority if (too_few) begin
        status   = ST_NOT_ENOUGH;
        newest_d = newest_nx;
      end else if (diff[TIME_W-1]) begin
        status = ST_SPAN_ERROR;
      end else begin
        newest_d = newest_nx;
        oldest_d = oldest_nx;
        priority if (!in_window) begin
          status = ST_WINDOW_MISSED;
        end else if (rate_limited) begin
          status = ST_RATE_LIMITED;
        end else begin
          status        = ST_REPORTED;
          last_report_d = press_time_ms_i;
        end
      end
    end
    if (!accept) begin
      ring_we       = 1'b0;
      newest_d      = newest_q;
      oldest_d      = oldest_q;
      last_accept_d = last_accept_q;
      last_report_d = last_report_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q      <= '0;
      oldest_q      <= '0;
      last_accept_q <= '0;
      last_report_q <= '0;
    end else begin
      newest_q      <= newest_d;
      oldest_q      <= oldest_d;
      last_accept_q <= last_accept_d;
      last_report_q <= last_report_d;
    end
  end

  // press ring: write newest, registered read of next oldest with bypass
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[newest_q] <= press_time_ms_i;
    end
    if (ring_we && (newest_q == oldest_d)) begin
      oldest_rd_q <= press_time_ms_i;
    end else begin
      oldest_rd_q <= ring_mem[oldest_d];
    end
  end

  // word to the back end
  assign q_push_o        = accept;
  assign q_word_o.status = status;
  assign q_word_o.diff   = diff[DIFF_W-1:0];

  // a raised report records its press time
  a_report_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_REPORTED) |=> (last_report_q == $past(press_time_ms_i)))
    else $error("report time not recorded");

  // a short ring never moves the oldest slot
  a_not_enough_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_NOT_ENOUGH) |=> $stable(oldest_q))
    else $error("oldest slot moved while filling");

  // ring slots stay inside the ring
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (newest_q <= IdxW'(MAX_PRESSES)) && (oldest_q <= IdxW'(MAX_PRESSES)))
    else $error("ring slot out of range");

endmodule

// ===== rtl/core/pbd_back.sv =====
`timescale 1ns / 1ps

module pbd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  pbd_pkg::press_word_t           q_word_i,
  output logic                           q_pop_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [2:0]                     status_o,
  output logic                           report_fired_o,
  output logic [pbd_pkg::SPAN_W-1:0]     span_seconds_o
);
  import pbd_pkg::*;

  logic                 s1_vld_q;
  status_e              s1_status_q;
  logic [PROD_W-1:0]    s1_prod_q;
  logic                 out_vld_q;
  status_e              out_status_q;
  logic [SPAN_W-1:0]    out_span_q;

  logic                 out_ready;
  logic                 s1_ready;
  logic                 s1_has_span;

  // flow control through the two stages
  assign out_ready = !out_vld_q || pop_i;
  assign s1_ready  = !s1_vld_q || out_ready;
  assign q_pop_o   = !q_empty_i && s1_ready;

  assign s1_has_span = (s1_status_q == ST_WINDOW_MISSED)
                    || (s1_status_q == ST_RATE_LIMITED)
                    || (s1_status_q == ST_REPORTED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_q <= q_pop_o;
      end
      if (out_ready) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // stage one: reciprocal multiply of the span in ms
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_status_q <= q_word_i.status;
      s1_prod_q   <= PROD_W'(q_word_i.diff[DIFF_W-1:DIV_PRE_SHIFT]) * PROD_W'(RECIP_125);
    end
  end

  // stage two: whole seconds into the output register, zero for words that carry no span
  always_ff @(posedge clk_i) begin
    if (s1_vld_q && out_ready) begin
      out_status_q <= s1_status_q;
      out_span_q   <= s1_has_span ? s1_prod_q[RECIP_SHIFT +: SPAN_W] : '0;
    end
  end

  assign empty_o        = !out_vld_q;
  assign status_o       = out_status_q;
  assign report_fired_o = (out_status_q == ST_REPORTED);
  assign span_seconds_o = out_span_q;

  // the multiply stage never drops a word while the output waits
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !pop_i) |=> s1_vld_q)
    else $error("stage one word lost");

endmodule

// ===== rtl/core/press_burst_detector_top.sv =====
`timescale 1ns / 1ps
// channel   | handshake                      | words
// ----------+--------------------------------+------------------------------------------
// press in  | push / full                    | press_time_ms_i
// result    | empty / pop                    | status_o, report_fired_o, span_seconds_o
// config    | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one press is taken every cycle while full is low; its result passes the queue, the multiply
// stage and the output register before it can be popped; the front decides each press against ms
// thresholds and a registered ring read; the back turns the span into seconds with one multiply stage
// reset clears indices and last times and loads register defaults at once; the press ring needs no clearing
// a four-word queue sits between front and back; full rises only when it fills under pop stalls
module press_burst_detector_top #(
  parameter int unsigned MAX_PRESSES = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [pbd_pkg::TIME_W-1:0]          press_time_ms_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [2:0]                          status_o,
  output logic                                report_fired_o,
  output logic [pbd_pkg::SPAN_W-1:0]          span_seconds_o
);
  import pbd_pkg::*;

  logic         mid_push;
  logic         mid_full;
  logic         mid_pop;
  logic         mid_empty;
  press_word_t  mid_in;
  press_word_t  mid_out;

  assign full = mid_full;

  // front: registers, classification and ring state
  pbd_front #(
    .MAX_PRESSES (MAX_PRESSES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push),
    .full_i          (mid_full),
    .press_time_ms_i (press_time_ms_i),
    .q_push_o        (mid_push),
    .q_word_o        (mid_in)
  );

  // queue between front and back
  pbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // back: span in seconds and result register
  pbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (mid_empty),
    .q_word_i       (mid_out),
    .q_pop_o        (mid_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .report_fired_o (report_fired_o),
    .span_seconds_o (span_seconds_o)
  );

endmodule
